// ----- rtl/core/stq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Request and result codes, slot status codes and the payload types.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_INIT    = 3'd2;
  localparam logic [2:0] REQ_SETTIME = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_TASK   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] ST_UNUSED  = 2'd0;
  localparam logic [1:0] ST_ALLOC   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hffffffff;
  localparam int unsigned MaxResults = 16;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot;
    logic [7:0]         fifo_handle;
    logic signed [31:0] data_word;
    logic [31:0]        delay;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [3:0]         result_slot;
    logic               ok;
    logic [7:0]         out_handle;
    logic signed [31:0] out_data;
    logic               last;
  } rsp_t;

endpackage

// ----- rtl/core/stq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface stq_req_if import stq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sorted_timer_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue core
// Timer slot pool with a due-time sorted linked list and a tick counter.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer carries
// req       in         one request: req_type, slot, fifo_handle, data_word, delay
// rsp       out        one result: kind, slot, ok, handle, data, last
// cfg       in         task_slot write, no handshake
//
// One request is taken at a time; req.ready is high only in the idle state, so
// it stays low until every result of a request has been transferred. Free, init
// and undefined requests offer their result on the cycle after acceptance.
// Alloc compares one slot status per cycle until it finds an unused slot or
// has checked all TIMER_SLOTS. Settime arms the slot, walks the list one link
// per cycle (the link memory has a single read port) and relinks it. A tick
// reads each slot examined in S_EXP and checks it in S_EXPRD, and each result
// waits for rsp.ready.
// Reset is asynchronous and empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core import stq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  stq_req_if.sink    req,
  stq_rsp_if.source  rsp
);

  localparam int unsigned IdxW = $clog2(TIMER_SLOTS);
  localparam int unsigned LnkW = IdxW + 1;
  localparam int unsigned CntW = LnkW + 1;
  localparam logic [LnkW-1:0] EndMark = LnkW'(TIMER_SLOTS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_ALLOC = 9'b0_0000_0010,
    S_ARM   = 9'b0_0000_0100,
    S_WALK  = 9'b0_0000_1000,
    S_LINK  = 9'b0_0001_0000,
    S_PLINK = 9'b0_0010_0000,
    S_EXP   = 9'b0_0100_0000,
    S_EXPRD = 9'b0_1000_0000,
    S_OUT   = 9'b1_0000_0000
  } state_e;

  state_e state_q;

  logic [4:0]      task_slot_q;
  logic [31:0]     tick_q;
  logic [31:0]     next_due_q;
  logic [LnkW-1:0] head_q;
  logic [1:0]      status_q [TIMER_SLOTS];

  // Slot memories, one read port each, read data registered.
  logic [31:0]     due_mem  [TIMER_SLOTS];
  logic [LnkW-1:0] link_mem [TIMER_SLOTS];
  logic [7:0]      hnd_mem  [TIMER_SLOTS];
  logic [31:0]     val_mem  [TIMER_SLOTS];
  logic [31:0]     due_rd_q;
  logic [LnkW-1:0] link_rd_q;
  logic [7:0]      hnd_rd_q;
  logic [31:0]     val_rd_q;

  req_t            r_q;
  logic [31:0]     due_q;    // due time being inserted
  logic [LnkW-1:0] cur_q, prev_q;
  logic [CntW-1:0] cnt_q;    // alloc scan index, walk guard, result count
  logic            ts_q;     // task slot expired in this walk, result owed
  logic            done_q;   // expiry walk has reached its end
  rsp_t            out_q;
  rsp_t            pend_q;   // expiry result held until last is known
  logic            pend_v_q;

  // Memory port controls from the sequencer.
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            lw_en;
  logic [IdxW-1:0] lw_addr;
  logic [LnkW-1:0] lw_data;

  function automatic rsp_t make_rsp(logic [1:0] kind, logic [3:0] slot, logic ok,
                                    logic [7:0] handle, logic [31:0] data,
                                    logic last);
    rsp_t r;
    r.result_kind = kind;
    r.result_slot = slot;
    r.ok          = ok;
    r.out_handle  = handle;
    r.out_data    = data;
    r.last        = last;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      due_rd_q  <= due_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
      hnd_rd_q  <= hnd_mem[rd_addr];
      val_rd_q  <= val_mem[rd_addr];
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (state_q == S_IDLE && req.valid && req.data.req_type == REQ_INIT
        && 32'(req.data.slot) < TIMER_SLOTS) begin
      hnd_mem[IdxW'(req.data.slot)] <= req.data.fifo_handle;
      val_mem[IdxW'(req.data.slot)] <= req.data.data_word;
    end
    if (state_q == S_ARM) begin
      due_mem[IdxW'(r_q.slot)] <= due_q;
    end
  end

  // Current candidate in the walk is compared against the registered read data.
  logic            walk_more, exp_due, is_task;
  logic [CntW-1:0] nres;
  assign walk_more = (cur_q != EndMark) && (cnt_q < CntW'(TIMER_SLOTS))
                     && (due_q > due_rd_q);
  assign exp_due   = (cur_q != EndMark) && (tick_q >= due_rd_q);
  assign is_task   = (32'(cur_q) == 32'(task_slot_q));
  assign nres      = cnt_q + CntW'(ts_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q[IdxW-1:0];
    lw_en   = 1'b0;
    lw_addr = IdxW'(r_q.slot);
    lw_data = cur_q;
    case (state_q)
      S_ARM, S_EXP: begin
        rd_en = (cur_q != EndMark);
      end
      S_WALK: begin
        if (walk_more) begin
          rd_en   = (link_rd_q != EndMark);
          rd_addr = link_rd_q[IdxW-1:0];
        end
      end
      S_LINK: begin
        // The new slot points at its successor.
        lw_en = 1'b1;
      end
      S_PLINK: begin
        // Its predecessor then points at the new slot.
        lw_en   = 1'b1;
        lw_addr = prev_q[IdxW-1:0];
        lw_data = LnkW'(r_q.slot);
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      task_slot_q <= 5'd16;
      tick_q      <= '0;
      next_due_q  <= ALL_ONES;
      head_q      <= EndMark;
      for (int i = 0; i < TIMER_SLOTS; i++) status_q[i] <= ST_UNUSED;
      r_q         <= '0;
      due_q       <= '0;
      cnt_q       <= '0;
      ts_q        <= 1'b0;
      done_q      <= 1'b0;
      cur_q       <= EndMark;
      prev_q      <= EndMark;
      out_q       <= '0;
      pend_q      <= '0;
      pend_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) task_slot_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            r_q   <= req.data;
            cnt_q <= '0;
            if (req.data.req_type == REQ_ALLOC) begin
              state_q <= S_ALLOC;
            end else if (req.data.req_type == REQ_TICK) begin
              tick_q   <= tick_q + 32'd1;
              ts_q     <= 1'b0;
              done_q   <= 1'b0;
              pend_v_q <= 1'b0;
              cur_q    <= head_q;
              // Nothing due: the tick gives no result at all.
              if (next_due_q <= tick_q + 32'd1) begin
                state_q <= S_EXP;
              end
            end else if (req.data.req_type > REQ_TICK) begin
              out_q   <= make_rsp(KIND_DONE, 4'd0, 1'b0, '0, '0, 1'b1);
              state_q <= S_OUT;
            end else if (32'(req.data.slot) >= TIMER_SLOTS) begin
              out_q   <= make_rsp(KIND_DONE, req.data.slot, 1'b0, '0, '0, 1'b1);
              state_q <= S_OUT;
            end else if (req.data.req_type == REQ_FREE) begin
              // A running slot stays armed and the free is refused.
              if (status_q[IdxW'(req.data.slot)] != ST_RUNNING) begin
                status_q[IdxW'(req.data.slot)] <= ST_UNUSED;
              end
              out_q <= make_rsp(KIND_DONE, req.data.slot,
                                status_q[IdxW'(req.data.slot)] != ST_RUNNING,
                                '0, '0, 1'b1);
              state_q <= S_OUT;
            end else if (req.data.req_type == REQ_INIT) begin
              out_q   <= make_rsp(KIND_DONE, req.data.slot, 1'b1, '0, '0, 1'b1);
              state_q <= S_OUT;
            end else if (status_q[IdxW'(req.data.slot)] != ST_RUNNING) begin
              status_q[IdxW'(req.data.slot)] <= ST_RUNNING;
              out_q   <= make_rsp(KIND_DONE, req.data.slot, 1'b1, '0, '0, 1'b1);
              due_q   <= tick_q + req.data.delay;
              cur_q   <= head_q;
              prev_q  <= EndMark;
              state_q <= S_ARM;
            end else begin
              out_q   <= make_rsp(KIND_DONE, req.data.slot, 1'b0, '0, '0, 1'b1);
              state_q <= S_OUT;
            end
          end
        end
        S_ALLOC: begin
          // One slot status compared per cycle.
          if (32'(cnt_q) >= TIMER_SLOTS) begin
            out_q   <= make_rsp(KIND_ALLOC, 4'd0, 1'b0, '0, '0, 1'b1);
            state_q <= S_OUT;
          end else if (status_q[cnt_q[IdxW-1:0]] == ST_UNUSED) begin
            status_q[cnt_q[IdxW-1:0]] <= ST_ALLOC;
            out_q   <= make_rsp(KIND_ALLOC, 4'(cnt_q), 1'b1, '0, '0, 1'b1);
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_ARM: state_q <= S_WALK;
        S_WALK: begin
          // Stops at the first slot whose due time is not earlier, so the new
          // slot goes ahead of equal due times.
          if (walk_more) begin
            prev_q <= cur_q;
            cur_q  <= link_rd_q;
            cnt_q  <= cnt_q + CntW'(1);
          end else begin
            state_q <= S_LINK;
            if (prev_q == EndMark) begin
              head_q     <= LnkW'(r_q.slot);
              next_due_q <= due_q;
            end
          end
        end
        S_LINK: begin
          if (prev_q != EndMark) begin
            state_q <= S_PLINK;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_PLINK: state_q <= S_OUT;
        S_EXP: state_q <= S_EXPRD;
        S_EXPRD: begin
          if (exp_due && 32'(nres) < MaxResults) begin
            status_q[cur_q[IdxW-1:0]] <= ST_ALLOC;
            cur_q <= link_rd_q;
            if (is_task) begin
              ts_q    <= 1'b1;
              state_q <= S_EXP;
            end else begin
              cnt_q    <= cnt_q + CntW'(1);
              pend_q   <= make_rsp(KIND_EXPIRY, 4'(cur_q), 1'b1, hnd_rd_q,
                                   val_rd_q, 1'b0);
              pend_v_q <= 1'b1;
              // A further expiry proves the held one is not the last.
              if (pend_v_q) begin
                out_q   <= pend_q;
                state_q <= S_OUT;
              end else begin
                state_q <= S_EXP;
              end
            end
          end else begin
            head_q     <= cur_q;
            next_due_q <= (cur_q != EndMark) ? due_rd_q : ALL_ONES;
            done_q     <= 1'b1;
            if (pend_v_q) begin
              out_q <= make_rsp(pend_q.result_kind, pend_q.result_slot, pend_q.ok,
                                pend_q.out_handle, pend_q.out_data, !ts_q);
              pend_v_q <= 1'b0;
              state_q  <= S_OUT;
            end else if (ts_q) begin
              out_q   <= make_rsp(KIND_TASK, 4'(task_slot_q), 1'b1, '0, '0, 1'b1);
              ts_q    <= 1'b0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (r_q.req_type != REQ_TICK) begin
              state_q <= S_IDLE;
            end else if (!done_q) begin
              state_q <= S_EXP;
            end else if (ts_q) begin
              // The task-switch result follows the last expiry.
              out_q <= make_rsp(KIND_TASK, 4'(task_slot_q), 1'b1, '0, '0, 1'b1);
              ts_q  <= 1'b0;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
